>>> hdl/gcsl_pkg.sv
package gcsl_pkg;

  localparam int CACHE_SLOTS = 256;
  localparam int SLOT_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int CNT_W = $clog2(CACHE_SLOTS + 1);
  localparam int EFF_W = (CNT_W > 9) ? CNT_W : 9;

  localparam int KEY_W = 17;
  localparam int OFFSET_W = 25;
  localparam int HEIGHT_W = 7;
  localparam int INUSE_W = 9;
  localparam int SIZE_W = 13;
  localparam int MUL_A_W = 14;
  localparam int OUT_SLOT_W = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [7:0] GB_LEAD_MIN = 8'hA0;
  localparam logic [7:0] GB_BASE = 8'hA1;
  localparam logic [7:0] GB_ROW_LEN = 8'h5E;
  localparam logic [7:0] DBCS_LEAD_MIN = 8'h80;
  localparam logic [KEY_W-1:0] ASCII_TAG = 17'h10000;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd16;
  localparam logic [INUSE_W-1:0] INUSE_RESET = 9'd256;

  typedef enum logic [0:0] {
    REG_GLYPH_HEIGHT = 1'b0,
    REG_SLOTS_IN_USE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] slot;
    logic miss;
    logic wide_glyph;
    logic [OFFSET_W-1:0] glyph_offset;
  } result_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic wide;
    logic [OFFSET_W-1:0] offset;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } back_state_t;

endpackage

>>> hdl/gcsl_front.sv
module gcsl_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  gcsl_pkg::item_t item,
  input  logic [gcsl_pkg::SIZE_W-1:0] glyph_size,
  output logic cmd_push,
  input  logic cmd_full,
  output gcsl_pkg::cmd_t cmd
);

  logic b_valid;
  logic [gcsl_pkg::KEY_W-1:0] b_key;
  logic b_wide;
  logic [7:0] b_first;

  logic [gcsl_pkg::KEY_W-1:0] key;
  logic wide;
  logic [6:0] row;
  logic [6:0] col;
  logic advance;
  logic take;
  logic [gcsl_pkg::MUL_A_W-1:0] mul_a;
  logic [gcsl_pkg::SIZE_W-1:0] mul_b;
  logic [gcsl_pkg::MUL_A_W+gcsl_pkg::SIZE_W-1:0] product;

  // Key formation: GB2312 row/cell index, a shared key for stray lead bytes,
  // or the ASCII code tagged with bit 16.
  always_comb begin
    row = 7'(item.first_byte - gcsl_pkg::GB_BASE);
    col = 7'(item.second_byte - gcsl_pkg::GB_BASE);
    if (item.first_byte > gcsl_pkg::GB_LEAD_MIN && item.second_byte > gcsl_pkg::GB_LEAD_MIN) begin
      key = gcsl_pkg::KEY_W'(gcsl_pkg::KEY_W'(row) * gcsl_pkg::KEY_W'(gcsl_pkg::GB_ROW_LEN)
            + gcsl_pkg::KEY_W'(col));
      wide = 1'b1;
    end else if (item.first_byte > gcsl_pkg::DBCS_LEAD_MIN) begin
      key = '0;
      wide = 1'b1;
    end else begin
      key = gcsl_pkg::KEY_W'(item.first_byte) | gcsl_pkg::ASCII_TAG;
      wide = 1'b0;
    end
  end

  assign advance = b_valid && !cmd_full;
  assign full = b_valid && !advance;
  assign take = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (take) begin
      b_valid <= 1'b1;
    end else if (advance) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_key <= key;
      b_wide <= wide;
      b_first <= item.first_byte;
    end
  end

  // A narrow glyph is half the byte size of a wide one.
  always_comb begin
    if (b_wide) begin
      mul_a = gcsl_pkg::MUL_A_W'(b_key);
      mul_b = glyph_size;
    end else begin
      mul_a = gcsl_pkg::MUL_A_W'(b_first);
      mul_b = glyph_size >> 1;
    end
    product = gcsl_pkg::MUL_A_W'(mul_a) * (gcsl_pkg::MUL_A_W + gcsl_pkg::SIZE_W)'(mul_b);
  end

  assign cmd_push = advance;
  assign cmd.key = b_key;
  assign cmd.wide = b_wide;
  assign cmd.offset = product[gcsl_pkg::OFFSET_W-1:0];

endmodule

>>> hdl/gcsl_fifo.sv
module gcsl_fifo (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  gcsl_pkg::cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output gcsl_pkg::cmd_t rd_data,
  output logic empty
);

  gcsl_pkg::cmd_t entries [gcsl_pkg::QUEUE_DEPTH];
  logic [gcsl_pkg::QPTR_W-1:0] wr_ptr;
  logic [gcsl_pkg::QPTR_W-1:0] rd_ptr;
  logic [gcsl_pkg::QCNT_W-1:0] count;
  logic do_wr;
  logic do_rd;

  assign full = (count == gcsl_pkg::QCNT_W'(gcsl_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> hdl/gcsl_back.sv
module gcsl_back (
  input  logic clk,
  input  logic rst,
  input  logic [gcsl_pkg::INUSE_W-1:0] slots_in_use,
  input  logic cmd_empty,
  input  gcsl_pkg::cmd_t cmd,
  output logic cmd_pop,
  output logic empty,
  input  logic pop,
  output gcsl_pkg::result_t result
);

  gcsl_pkg::back_state_t state, state_next;

  logic [gcsl_pkg::KEY_W-1:0] slot_key [gcsl_pkg::CACHE_SLOTS];
  logic [gcsl_pkg::CACHE_SLOTS-1:0] slot_valid;
  logic [gcsl_pkg::SLOT_W-1:0] replace_pointer, replace_pointer_next;

  gcsl_pkg::cmd_t cur;
  logic [gcsl_pkg::EFF_W-1:0] rd_idx, rd_idx_next;
  logic cmp_valid, cmp_valid_next;
  logic [gcsl_pkg::SLOT_W-1:0] cmp_idx;
  logic [gcsl_pkg::KEY_W-1:0] key_rd;
  logic valid_rd;

  logic [gcsl_pkg::SLOT_W-1:0] res_slot;
  logic res_miss;
  logic out_valid, out_valid_next;

  logic [gcsl_pkg::EFF_W-1:0] n_eff;
  logic issue;
  logic hit;
  logic alloc;
  logic finish;
  logic out_load;
  logic [gcsl_pkg::SLOT_W-1:0] alloc_slot;
  logic [gcsl_pkg::EFF_W-1:0] alloc_inc;

  // Out-of-range slot counts are clamped to one and to the cache size.
  always_comb begin
    if (slots_in_use == '0) begin
      n_eff = gcsl_pkg::EFF_W'(1);
    end else if (gcsl_pkg::EFF_W'(slots_in_use) > gcsl_pkg::EFF_W'(gcsl_pkg::CACHE_SLOTS)) begin
      n_eff = gcsl_pkg::EFF_W'(gcsl_pkg::CACHE_SLOTS);
    end else begin
      n_eff = gcsl_pkg::EFF_W'(slots_in_use);
    end
  end

  // A pointer left beyond a shrunken slot count wraps to zero first.
  always_comb begin
    if (gcsl_pkg::EFF_W'(replace_pointer) >= n_eff) begin
      alloc_slot = '0;
    end else begin
      alloc_slot = replace_pointer;
    end
    alloc_inc = gcsl_pkg::EFF_W'(alloc_slot) + gcsl_pkg::EFF_W'(1);
  end

  assign issue = (state == gcsl_pkg::BK_SCAN) && (rd_idx < n_eff);
  assign hit = cmp_valid && valid_rd && (key_rd == cur.key);

  always_comb begin
    state_next = state;
    rd_idx_next = rd_idx;
    cmp_valid_next = 1'b0;
    cmd_pop = 1'b0;
    alloc = 1'b0;
    finish = 1'b0;
    out_load = 1'b0;
    replace_pointer_next = replace_pointer;
    unique case (state)
      gcsl_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          rd_idx_next = '0;
          state_next = gcsl_pkg::BK_SCAN;
        end
      end
      gcsl_pkg::BK_SCAN: begin
        if (issue) begin
          rd_idx_next = rd_idx + gcsl_pkg::EFF_W'(1);
          cmp_valid_next = 1'b1;
        end
        // Reads go out in index order, so the first hit is the lowest slot.
        if (hit) begin
          finish = 1'b1;
          state_next = gcsl_pkg::BK_DONE;
        end else if (!issue && !cmp_valid) begin
          alloc = 1'b1;
          finish = 1'b1;
          if (alloc_inc >= n_eff) begin
            replace_pointer_next = '0;
          end else begin
            replace_pointer_next = gcsl_pkg::SLOT_W'(alloc_inc);
          end
          state_next = gcsl_pkg::BK_DONE;
        end
      end
      gcsl_pkg::BK_DONE: begin
        if (!out_valid || pop) begin
          out_load = 1'b1;
          state_next = gcsl_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = gcsl_pkg::BK_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (pop) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcsl_pkg::BK_IDLE;
      rd_idx <= '0;
      cmp_valid <= 1'b0;
      replace_pointer <= '0;
      out_valid <= 1'b0;
      slot_valid <= '0;
    end else begin
      state <= state_next;
      rd_idx <= rd_idx_next;
      cmp_valid <= cmp_valid_next;
      replace_pointer <= replace_pointer_next;
      out_valid <= out_valid_next;
      if (alloc) begin
        slot_valid[alloc_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) begin
      slot_key[alloc_slot] <= cur.key;
    end
    if (issue) begin
      key_rd <= slot_key[rd_idx[gcsl_pkg::SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (issue) begin
      valid_rd <= slot_valid[rd_idx[gcsl_pkg::SLOT_W-1:0]];
      cmp_idx <= rd_idx[gcsl_pkg::SLOT_W-1:0];
    end
    if (finish) begin
      res_slot <= hit ? cmp_idx : alloc_slot;
      res_miss <= !hit;
    end
    if (out_load) begin
      result.slot <= gcsl_pkg::OUT_SLOT_W'(res_slot);
      result.miss <= res_miss;
      result.wide_glyph <= cur.wide;
      result.glyph_offset <= cur.offset;
    end
  end

  assign empty = !out_valid;

endmodule

>>> hdl/glyph_cache_slot_lookup_core.sv
// On a miss the tag scan covers all n slots, where n is the effective slot count; a hit
// in slot i ends the scan at that slot. The back end works on one beat at a time, and
// its tag scan reads one tag store entry per cycle through a single memory read port.
// Reset clears the valid bits, the replacement pointer and the queues and loads the
// registers with height 16 and 256 slots; the tag store itself is not cleared.
module glyph_cache_slot_lookup_core (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  gcsl_pkg::item_t item,
  output logic empty,
  input  logic pop,
  output gcsl_pkg::result_t result,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic [gcsl_pkg::HEIGHT_W-1:0] glyph_height;
  logic [gcsl_pkg::INUSE_W-1:0] slots_in_use;
  logic [gcsl_pkg::SIZE_W-1:0] glyph_size;
  gcsl_pkg::reg_index_t reg_sel;
  logic cfg_write;

  logic cmd_push;
  logic cmd_full;
  gcsl_pkg::cmd_t cmd_in;
  logic cmd_pop;
  logic cmd_empty;
  gcsl_pkg::cmd_t cmd_out;

  assign pready = 1'b1;
  assign reg_sel = gcsl_pkg::reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_height <= gcsl_pkg::HEIGHT_RESET;
      slots_in_use <= gcsl_pkg::INUSE_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        gcsl_pkg::REG_GLYPH_HEIGHT: glyph_height <= pwdata[gcsl_pkg::HEIGHT_W-1:0];
        gcsl_pkg::REG_SLOTS_IN_USE: slots_in_use <= pwdata[gcsl_pkg::INUSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      gcsl_pkg::REG_GLYPH_HEIGHT: prdata = 32'(glyph_height);
      gcsl_pkg::REG_SLOTS_IN_USE: prdata = 32'(slots_in_use);
      default: prdata = '0;
    endcase
  end

  // Bytes of one wide glyph, (h/2) * h, kept in a register ahead of the offset multiply.
  always_ff @(posedge clk) begin
    glyph_size <= gcsl_pkg::SIZE_W'(gcsl_pkg::SIZE_W'(glyph_height >> 1)
                  * gcsl_pkg::SIZE_W'(glyph_height));
  end

  gcsl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .glyph_size (glyph_size),
    .cmd_push   (cmd_push),
    .cmd_full   (cmd_full),
    .cmd        (cmd_in)
  );

  gcsl_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  gcsl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .slots_in_use (slots_in_use),
    .cmd_empty    (cmd_empty),
    .cmd          (cmd_out),
    .cmd_pop      (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .result       (result)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // Holds a copy of the tag store and the registers, works out the lookup for
  // every accepted character and compares the results in order.
  class glyph_scoreboard;
    logic [gcsl_pkg::KEY_W-1:0] tag_store [gcsl_pkg::CACHE_SLOTS];
    bit tag_valid [gcsl_pkg::CACHE_SLOTS];
    int unsigned next_victim;
    int unsigned height;
    int unsigned slots_in_use;
    gcsl_pkg::result_t expected_glyphs [$];
    int unsigned failures;

    function new();
      foreach (tag_valid[i]) tag_valid[i] = 1'b0;
      next_victim = 0;
      height = 16;
      slots_in_use = 256;
      failures = 0;
    endfunction

    function void set_register(gcsl_pkg::reg_index_t idx, logic [31:0] value);
      if (idx == gcsl_pkg::REG_GLYPH_HEIGHT) begin
        height = 32'(value[gcsl_pkg::HEIGHT_W-1:0]);
      end else begin
        slots_in_use = 32'(value[gcsl_pkg::INUSE_W-1:0]);
      end
    endfunction

    function void lookup_glyph(gcsl_pkg::item_t c);
      int unsigned b0, b1, key, n;
      int found;
      bit wide;
      gcsl_pkg::result_t r;
      b0 = 32'(c.first_byte);
      b1 = 32'(c.second_byte);
      if (b0 > 'hA0 && b1 > 'hA0) begin
        key = (b0 - 'hA1) * 'h5E + (b1 - 'hA1);
        wide = 1'b1;
      end else if (b0 > 'h80) begin
        key = 0;
        wide = 1'b1;
      end else begin
        key = b0 | 'h10000;
        wide = 1'b0;
      end
      if (wide) begin
        r.glyph_offset = gcsl_pkg::OFFSET_W'(key * ((height / 2) * height));
      end else begin
        r.glyph_offset = gcsl_pkg::OFFSET_W'(b0 * ((height * (height / 2)) / 2));
      end
      r.wide_glyph = wide;

      // A register value of zero behaves as one; large values saturate.
      n = (slots_in_use == 0) ? 1 : slots_in_use;
      if (n > gcsl_pkg::CACHE_SLOTS) n = gcsl_pkg::CACHE_SLOTS;

      found = -1;
      for (int i = 0; i < n; i++) begin
        if (tag_valid[i] && tag_store[i] == key[gcsl_pkg::KEY_W-1:0]) begin
          found = i;
          break;
        end
      end

      if (found < 0) begin
        // The pointer may sit past the end after the slot count shrank.
        if (next_victim >= n) next_victim = 0;
        found = next_victim;
        next_victim++;
        if (next_victim >= n) next_victim = 0;
        tag_store[found] = key[gcsl_pkg::KEY_W-1:0];
        tag_valid[found] = 1'b1;
        r.miss = 1'b1;
      end else begin
        r.miss = 1'b0;
      end
      r.slot = 8'(found);
      expected_glyphs.push_back(r);
    endfunction

    function void check_glyph(gcsl_pkg::result_t got);
      gcsl_pkg::result_t want;
      if (expected_glyphs.size() == 0) begin
        $error("unexpected result beat: slot %0d", got.slot);
        failures++;
        return;
      end
      want = expected_glyphs.pop_front();
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, got.slot);
        failures++;
      end
      if (got.miss !== want.miss) begin
        $error("miss: expected %0d, got %0d", want.miss, got.miss);
        failures++;
      end
      if (got.wide_glyph !== want.wide_glyph) begin
        $error("wide_glyph: expected %0d, got %0d", want.wide_glyph, got.wide_glyph);
        failures++;
      end
      if (got.glyph_offset !== want.glyph_offset) begin
        $error("glyph_offset: expected %0d, got %0d", want.glyph_offset, got.glyph_offset);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic push;
  logic full;
  gcsl_pkg::item_t item;
  logic empty;
  logic pop;
  gcsl_pkg::result_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  glyph_scoreboard book = new();
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_request;
  gcsl_pkg::item_t char_pool [$];

  glyph_cache_slot_lookup_core DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        book.set_register(gcsl_pkg::reg_index_t'(paddr[2]), pwdata);
      end
      if (push && !full) book.lookup_glyph(item);
      if (pop && !empty) book.check_glyph(result);
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic write_reg(gcsl_pkg::reg_index_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_char(gcsl_pkg::item_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= c;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (book.expected_glyphs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic gcsl_pkg::item_t make_char();
    gcsl_pkg::item_t c;
    case ($urandom_range(3))
      0: begin
        c.first_byte = 8'($urandom_range('hA1, 'hFF));
        c.second_byte = 8'($urandom_range('hA1, 'hFF));
      end
      1: begin
        c.first_byte = 8'($urandom_range('h81, 'hFF));
        c.second_byte = (c.first_byte > 'hA0) ? 8'($urandom_range(0, 'hA0))
                                              : 8'($urandom_range(0, 255));
      end
      2: begin
        c.first_byte = 8'($urandom_range(0, 'h80));
        c.second_byte = 8'($urandom_range(0, 255));
      end
      default: c = gcsl_pkg::item_t'(16'($urandom));
    endcase
    return c;
  endfunction

  // Mostly characters from a small working set so that hits and evictions both occur.
  function automatic gcsl_pkg::item_t pick_char();
    if ($urandom_range(99) < 65) return char_pool[$urandom_range(char_pool.size() - 1)];
    return make_char();
  endfunction

  task automatic run_phase(int unsigned height, int unsigned slots, int unsigned count,
                           int unsigned tx_pct, int unsigned rx_pct, bit long_hold);
    int unsigned pool_size;
    drain_results();
    write_reg(gcsl_pkg::REG_GLYPH_HEIGHT, height);
    write_reg(gcsl_pkg::REG_SLOTS_IN_USE, slots);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    pool_size = $urandom_range(3, 12);
    char_pool = {};
    repeat (pool_size) char_pool.push_back(make_char());
    for (int i = 0; i < count; i++) begin
      if (long_hold && i == 10) hold_request = 600;
      send_char(pick_char());
    end
    push <= 1'b0;
  endtask

  logic [15:0] directed_chars [20] = '{
    16'h0000, 16'h80FF, 16'h7F80, 16'h8100, 16'h81A0, 16'hA0FF, 16'hA1A0, 16'hA1A1,
    16'hA1A2, 16'hFFFF, 16'hFEA1, 16'h4141, 16'h0000, 16'hFFFF, 16'hA0A1, 16'hFF00,
    16'h2AD5, 16'h5580, 16'hAAAA, 16'h01FE
  };

  initial begin
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_idle_pct = 16;
    rx_idle_pct = 68;
    hold_request = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Boundaries of the three key kinds at the reset register values.
    foreach (directed_chars[i]) send_char(gcsl_pkg::item_t'(directed_chars[i]));
    push <= 1'b0;

    run_phase(64, 1, 150, 16, 68, 1'b0);
    run_phase(2, 4, 200, 16, 68, 1'b1);
    run_phase(16, 256, 120, 16, 68, 1'b0);
    run_phase(0, 0, 200, 68, 16, 1'b0);
    run_phase(127, 511, 100, 68, 16, 1'b0);
    run_phase(33, 16, 250, 68, 16, 1'b0);
    run_phase(1, 2, 200, 0, 0, 1'b0);
    run_phase($urandom_range(2, 64), $urandom_range(1, 40), 250, 0, 0, 1'b0);
    run_phase(64, 300, 100, 0, 0, 1'b0);
    run_phase(16, 3, 230, 0, 0, 1'b0);

    drain_results();
    repeat (300) @(posedge clk);
    if (book.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/gcsl_pkg.sv
hdl/gcsl_front.sv
hdl/gcsl_fifo.sv
hdl/gcsl_back.sv
hdl/glyph_cache_slot_lookup_core.sv
tb/sv/testbench.sv
